/* hw/rtl/skf_pkg.sv */
// Package for the scalar Kalman filter: fixed-point formats, register map,
// command and status types shared by the controller, datapath and registers.
// Depends on nothing.
package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NOISE_W   = 16;
  localparam int ADDR_W    = 3;
  localparam int PDATA_W   = 32;

  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int DEN_W     = DATA_W + 1;
  localparam int REM_W     = DEN_W + 1;
  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PROD_C_W  = DATA_W + 1 + GAIN_W + 1;
  localparam int PROD_P_W  = DATA_W + GAIN_W;

  localparam int NOISE_SHL = (FRAC_BITS >= NOISE_W) ? FRAC_BITS - NOISE_W : 0;
  localparam int NOISE_SHR = (FRAC_BITS < NOISE_W) ? NOISE_W - FRAC_BITS : 0;

  localparam logic [GAIN_W-1:0] ONE      = GAIN_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] P_RESET  = DATA_W'(1) << FRAC_BITS;
  localparam logic [NOISE_W-1:0] Q_RESET = NOISE_W'(655);
  localparam logic [NOISE_W-1:0] R_RESET = NOISE_W'(6554);

  localparam logic REG_PROCESS_NOISE = 1'b0;
  localparam logic REG_MEASURE_NOISE = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic [NOISE_W-1:0] process_noise;
    logic [NOISE_W-1:0] measure_noise;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic mult;
    logic finish;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  function automatic logic [DATA_W-1:0] noise_to_frac(input logic [NOISE_W-1:0] v);
    return (DATA_W'(v) << NOISE_SHL) >> NOISE_SHR;
  endfunction

endpackage

/* hw/rtl/skf_channels.sv */
// Valid/ready channel interfaces for the scalar Kalman filter input and output.
// Depends on skf_pkg.
interface skf_in_if;
  logic valid;
  logic ready;
  skf_pkg::data_t measured;
  skf_pkg::data_t predicted;

  modport source (output valid, output measured, output predicted, input ready);
  modport sink (input valid, input measured, input predicted, output ready);
endinterface

interface skf_out_if;
  logic valid;
  logic ready;
  skf_pkg::data_t estimate;

  modport source (output valid, output estimate, input ready);
  modport sink (input valid, input estimate, output ready);
endinterface

/* hw/rtl/skf_regs.sv */
// APB-style configuration registers holding the process and measurement noise.
// Depends on skf_pkg.
module skf_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skf_pkg::ADDR_W-1:0]  paddr,
  input  logic [skf_pkg::PDATA_W-1:0] pwdata,
  output logic [skf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output skf_pkg::cfg_t               cfg
);
  import skf_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.process_noise <= Q_RESET;
      cfg.measure_noise <= R_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PROCESS_NOISE: cfg.process_noise <= pwdata[NOISE_W-1:0];
        REG_MEASURE_NOISE: cfg.measure_noise <= pwdata[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PROCESS_NOISE: prdata = PDATA_W'(cfg.process_noise);
      REG_MEASURE_NOISE: prdata = PDATA_W'(cfg.measure_noise);
      default:           prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/skf_ctrl.sv */
// Controller state machine sequencing one filter update through the datapath.
// Depends on skf_pkg.
module skf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  skf_pkg::status_t status,
  output skf_pkg::cmd_t    cmd
);
  import skf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEN  = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             div_last;

  assign in_ready = (state == S_IDLE);
  assign div_last = (cnt == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mult   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= div_last ? '0 : cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

endmodule

/* hw/rtl/skf_datapath.sv */
// Datapath: covariance prediction, restoring gain divider, the two products,
// estimate saturation, covariance state and the output register.
// Depends on skf_pkg.
module skf_datapath (
  input  logic             clk,
  input  logic             rst,
  input  skf_pkg::cmd_t    cmd,
  input  skf_pkg::cfg_t    cfg,
  input  skf_pkg::data_t   measured,
  input  skf_pkg::data_t   predicted,
  input  logic             out_ready,
  output logic             out_valid,
  output skf_pkg::data_t   estimate,
  output skf_pkg::status_t status
);
  import skf_pkg::*;

  localparam logic [DATA_W-1:0] EST_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] EST_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  data_t                       z_r;
  data_t                       x_r;
  logic [DATA_W-1:0]           cov;
  logic [DATA_W-1:0]           pp_r;
  logic [DEN_W-1:0]            den_r;
  logic [REM_W-1:0]            rem_r;
  logic [GAIN_W-1:0]           q_r;
  logic signed [PROD_C_W-1:0]  prod_c_r;
  logic [PROD_P_W-1:0]         prod_p_r;
  data_t                       est_r;

  logic [DATA_W:0]             pp_sum;
  logic [DATA_W-1:0]           pp_sat;
  logic                        ge;
  logic [REM_W-1:0]            rem_sub;
  logic [GAIN_W-1:0]           gain;
  logic signed [DATA_W:0]      diff;
  logic signed [PROD_C_W-1:0]  rounded;
  logic signed [PROD_C_W-1:0]  corr;
  logic signed [PROD_C_W-1:0]  est_sum;
  logic [PROD_C_W-DATA_W:0]    est_hi;
  logic [DATA_W-1:0]           est_sat;

  assign pp_sum  = {1'b0, cov} + {1'b0, noise_to_frac(cfg.process_noise)};
  assign pp_sat  = pp_sum[DATA_W] ? {DATA_W{1'b1}} : pp_sum[DATA_W-1:0];

  assign ge      = (rem_r >= REM_W'(den_r));
  assign rem_sub = ge ? rem_r - REM_W'(den_r) : rem_r;

  assign gain    = (den_r == '0) ? '0 : q_r;
  assign diff    = $signed({z_r[DATA_W-1], z_r}) - $signed({x_r[DATA_W-1], x_r});

  assign rounded = prod_c_r + $signed(PROD_C_W'(ONE >> 1));
  assign corr    = rounded >>> FRAC_BITS;
  assign est_sum = $signed({{(PROD_C_W-DATA_W){x_r[DATA_W-1]}}, x_r}) + corr;
  assign est_hi  = est_sum[PROD_C_W-1:DATA_W-1];

  always_comb begin
    if ((&est_hi) || !(|est_hi)) begin
      est_sat = est_sum[DATA_W-1:0];
    end else if (est_sum[PROD_C_W-1]) begin
      est_sat = EST_MIN;
    end else begin
      est_sat = EST_MAX;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_r  <= measured;
      x_r  <= predicted;
      pp_r <= pp_sat;
    end
    if (cmd.div_init) begin
      den_r <= {1'b0, pp_r} + DEN_W'(noise_to_frac(cfg.measure_noise));
      rem_r <= REM_W'(pp_r);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= {rem_sub[REM_W-2:0], 1'b0};
      q_r   <= {q_r[GAIN_W-2:0], ge};
    end
    if (cmd.mult) begin
      prod_c_r <= PROD_C_W'(diff) * PROD_C_W'($signed({1'b0, gain}));
      prod_p_r <= PROD_P_W'(ONE - gain) * PROD_P_W'(pp_r);
    end
    if (cmd.finish) begin
      est_r <= est_sat;
    end
    if (cmd.push) begin
      estimate <= est_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cov       <= P_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        cov <= prod_p_r[FRAC_BITS +: DATA_W];
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/scalar_kalman_filter_top.sv */
// Scalar Kalman filter top level: APB-style noise registers, controller and
// datapath joined by command and status structs.
// Depends on skf_pkg, skf_channels, skf_regs, skf_ctrl and skf_datapath.
//
// The input channel carries a measured and a predicted value in signed Q16.16;
// each transfer yields one transfer on the output channel with the filtered
// estimate, saturated to the signed 32-bit range. The APB port sets the process
// noise (address 0) and measurement noise (address 4), both unsigned Q0.16.
// Each item passes through these steps in order: accepting it and forming the
// predicted covariance, forming the divider denominator, 17 iterations of
// the restoring divider that produces the gain one bit per cycle, the two
// multiplications, rounding and saturation, and loading the output register.
// The result becomes valid in the same cycle in which a new input can first
// be accepted, while the result may still wait in the output register. If the
// receiver stalls with a result still held, the next result waits inside the
// block and no further input is accepted.
// Reset sets the covariance to 1.0, the noise registers to their defaults
// (0.01 and 0.1), and empties the output register.
module scalar_kalman_filter_top (
  input  logic                        clk,
  input  logic                        rst,
  skf_in_if.sink                      in_ch,
  skf_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skf_pkg::ADDR_W-1:0]  paddr,
  input  logic [skf_pkg::PDATA_W-1:0] pwdata,
  output logic [skf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import skf_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  skf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  skf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  skf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .measured  (in_ch.measured),
    .predicted (in_ch.predicted),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .estimate  (out_ch.estimate),
    .status    (status)
  );

endmodule
